>>> hdl/msre_pkg.sv
// Shared types and constants for the mask scanline run encoder.
package msre_pkg;

    localparam int MAX_EXTENT_DEF = 254;

    localparam logic [7:0] LINE_END  = 8'hFF;
    localparam logic [7:0] HDR_ROWS  = 8'h68;   // 'h'
    localparam logic [7:0] HDR_COLS  = 8'h76;   // 'v'

    localparam logic [1:0] REG_BOX_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOX_TOP    = 2'd1;
    localparam logic [1:0] REG_BOX_WIDTH  = 2'd2;
    localparam logic [1:0] REG_BOX_HEIGHT = 2'd3;

    localparam int JOB_BYTES  = 5;
    localparam int JOB_CNT_W  = $clog2(JOB_BYTES + 1);
    localparam int JOB_IDX_W  = $clog2(JOB_BYTES);
    localparam int JOBQ_DEPTH = 4;

    typedef struct packed {
        logic command;
        logic inside_req;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       frame_done;
    } out_word_t;

    // One accepted word turned into the bytes it produces.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [JOB_CNT_W-1:0]      count;
        logic                      done;
    } job_t;

    // Handshake between job queue and its neighbours.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> hdl/msre_front.sv
// Front end: configuration registers, scan state and run detection per word.
module msre_front #(
    parameter int MAX_EXTENT = msre_pkg::MAX_EXTENT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  msre_pkg::in_word_t s_data,
    input  msre_pkg::q_status_t q_stat,
    output logic               q_push,
    output msre_pkg::job_t     q_job
);
    import msre_pkg::*;

    localparam logic [7:0] EXT_MAX = 8'(MAX_EXTENT);
    localparam logic [7:0] ORG_MAX = 8'(MAX_EXTENT - 1);

    logic [7:0] left_reg, top_reg, width_reg, height_reg;
    logic       rows_reg, rows_next;
    logic [7:0] minor_reg, minor_next;
    logic [7:0] major_reg, major_next;
    logic       open_reg, open_next;
    logic [7:0] begin_reg, begin_next;
    logic       active_reg, active_next;

    logic       accept;
    logic [7:0] w, h, org_l, org_t, minor_len, major_len;
    logic [7:0] minor_inc, major_inc, rb, run_len;
    logic       open_mid, close_now, eol, run_close, done;
    job_t       job;
    logic       has_bytes;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        w     = (width_reg == 8'd0) ? 8'd1 : ((width_reg > EXT_MAX) ? EXT_MAX : width_reg);
        h     = (height_reg == 8'd0) ? 8'd1 : ((height_reg > EXT_MAX) ? EXT_MAX : height_reg);
        org_l = (left_reg > ORG_MAX) ? ORG_MAX : left_reg;
        org_t = (top_reg > ORG_MAX) ? ORG_MAX : top_reg;
        minor_len = rows_reg ? w : h;
        major_len = rows_reg ? h : w;

        // a zero pixel closes an open run before the position advances
        close_now = !s_data.inside_req && open_reg;
        open_mid  = s_data.inside_req;
        rb        = (s_data.inside_req && !open_reg) ? minor_reg : begin_reg;
        minor_inc = minor_reg + 8'd1;
        major_inc = major_reg + 8'd1;
        eol       = minor_inc >= minor_len;
        run_close = close_now || (eol && open_mid);
        run_len   = close_now ? (minor_reg - rb) : (minor_inc - rb);
        done      = eol && (major_inc >= major_len);

        rows_next   = rows_reg;
        minor_next  = minor_reg;
        major_next  = major_reg;
        open_next   = open_reg;
        begin_next  = begin_reg;
        active_next = active_reg;

        job       = '0;
        has_bytes = 1'b0;

        if (!s_data.command) begin
            rows_next   = (w >= h);
            minor_next  = '0;
            major_next  = '0;
            open_next   = 1'b0;
            begin_next  = '0;
            active_next = 1'b1;
            job.bytes[0] = (w >= h) ? HDR_ROWS : HDR_COLS;
            job.bytes[1] = org_l;
            job.bytes[2] = org_t;
            job.bytes[3] = w;
            job.bytes[4] = h;
            job.count    = JOB_CNT_W'(5);
            has_bytes    = 1'b1;
        end else if (active_reg) begin
            begin_next = rb;
            open_next  = open_mid && !eol;
            minor_next = eol ? 8'd0 : minor_inc;
            if (eol) begin
                major_next = major_inc;
                if (done) begin
                    active_next = 1'b0;
                end
            end
            if (run_close) begin
                job.bytes[0] = rb;
                job.bytes[1] = run_len;
                job.bytes[2] = LINE_END;
                job.count    = eol ? JOB_CNT_W'(3) : JOB_CNT_W'(2);
            end else begin
                job.bytes[0] = LINE_END;
                job.count    = eol ? JOB_CNT_W'(1) : JOB_CNT_W'(0);
            end
            job.done  = done;
            has_bytes = run_close || eol;
        end
    end

    assign q_push = accept && has_bytes;
    assign q_job  = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= 8'd0;
            top_reg    <= 8'd0;
            width_reg  <= 8'd1;
            height_reg <= 8'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BOX_LEFT:   left_reg   <= cfg_wdata;
                REG_BOX_TOP:    top_reg    <= cfg_wdata;
                REG_BOX_WIDTH:  width_reg  <= cfg_wdata;
                REG_BOX_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg   <= 1'b0;
            minor_reg  <= 8'd0;
            major_reg  <= 8'd0;
            open_reg   <= 1'b0;
            begin_reg  <= 8'd0;
            active_reg <= 1'b0;
        end else if (accept) begin
            rows_reg   <= rows_next;
            minor_reg  <= minor_next;
            major_reg  <= major_next;
            open_reg   <= open_next;
            begin_reg  <= begin_next;
            active_reg <= active_next;
        end
    end

endmodule

>>> hdl/msre_jobq.sv
// Short job queue between front end and byte emitter.
module msre_jobq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  msre_pkg::job_t      din,
    input  logic                pop,
    output msre_pkg::job_t      dout,
    output msre_pkg::q_status_t stat
);
    import msre_pkg::*;

    localparam int PTR_W = $clog2(JOBQ_DEPTH);
    localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

    job_t             mem_reg [JOBQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(JOBQ_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign dout       = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/msre_back.sv
// Back end: walks each queued job and emits its bytes one word per cycle while the output is not stalled.
module msre_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  msre_pkg::job_t      job,
    input  msre_pkg::q_status_t q_stat,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output msre_pkg::out_word_t m_data
);
    import msre_pkg::*;

    logic [JOB_IDX_W-1:0] idx_reg;
    logic                 valid_reg;
    out_word_t            data_reg;
    logic                 load, last_byte;

    // refill the output register when it is empty or being taken
    assign load      = !q_stat.empty && (!valid_reg || m_ready);
    assign last_byte = (JOB_CNT_W'(idx_reg) + JOB_CNT_W'(1)) == job.count;
    assign q_pop     = load && last_byte;
    assign m_valid   = valid_reg;
    assign m_data    = data_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg.out_byte   <= job.bytes[idx_reg];
            data_reg.last       <= last_byte;
            data_reg.frame_done <= last_byte && job.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= last_byte ? '0 : idx_reg + 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/mask_scanline_run_encoder.sv
// Top level of the mask scanline run encoder.
// A word with command 0 starts a frame and produces a five-byte header; each
// following pixel word produces nothing, a run (start, length), an end-of-line
// byte 0xFF, or a run followed by 0xFF. The front end takes one word per cycle
// as long as the four-entry job queue has room; the back end drains the queue
// at one output byte per cycle while the output is taken. Sustained throughput
// is therefore set by the output byte count: a header is five bytes, a closing
// run two, a line end one more; a pixel that produces nothing adds no bytes.
// A job passes through the queue and the output register before its first byte.
module mask_scanline_run_encoder #(
    parameter int MAX_EXTENT = msre_pkg::MAX_EXTENT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  msre_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output msre_pkg::out_word_t m_data
);
    import msre_pkg::*;

    job_t      push_job, head_job;
    logic      push, pop;
    q_status_t q_stat;

    msre_front #(
        .MAX_EXTENT(MAX_EXTENT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_stat    (q_stat),
        .q_push    (push),
        .q_job     (push_job)
    );

    msre_jobq u_jobq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_job),
        .pop     (pop),
        .dout    (head_job),
        .stat    (q_stat)
    );

    msre_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .job     (head_job),
        .q_stat  (q_stat),
        .q_pop   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> hdl/msre_checker.sv
// Port-level checks for the mask scanline run encoder, bound to the top level.
module msre_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input msre_pkg::out_word_t m_data
);
    import msre_pkg::*;

    // stalled output word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // frame end flag only on the final line marker
    a_done_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_done |-> m_data.last && (m_data.out_byte == LINE_END))
        else $error("frame_done on a byte other than the closing marker");

    // 0xFF only ever appears as the line marker, which ends its word's bytes
    a_eol_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.out_byte == LINE_END) |-> m_data.last)
        else $error("line marker not flagged last");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind mask_scanline_run_encoder msre_checker u_msre_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> tb/sv/tb_mask_scanline_run_encoder.sv
// Self-checking testbench for the mask scanline run encoder: directed frames, random ones, then more directed ones.
module tb_mask_scanline_run_encoder;
    import msre_pkg::*;

    localparam logic CMD_BEGIN    = 1'b0;
    localparam logic CMD_PIXEL    = 1'b1;
    localparam int   SETTLE_CYCLES = 10;
    localparam int   LIMIT_CYCLES  = 400000;
    localparam int   MAX_REPORTS   = 100;

    // Tracks box registers and scan position, and holds the bytes still owed by the block.
    class rle_byte_tracker;
        logic [7:0] box_left, box_top, box_width, box_height;
        bit         rows_first, run_open, frame_open;
        logic [7:0] minor_pos, major_pos, run_start;
        out_word_t  expected_bytes[$];
        out_word_t  burst[$];
        int         n_coded, n_frames, n_checked, n_errors, n_configs;

        function new();
            box_left   = 8'd0;
            box_top    = 8'd0;
            box_width  = 8'd1;
            box_height = 8'd1;
            rows_first = 1'b0;
            run_open   = 1'b0;
            frame_open = 1'b0;
            minor_pos  = 8'd0;
            major_pos  = 8'd0;
            run_start  = 8'd0;
            n_coded    = 0;
            n_frames   = 0;
            n_checked  = 0;
            n_errors   = 0;
            n_configs  = 0;
        endfunction

        function logic [7:0] sat_extent(logic [7:0] v);
            if (v == 8'd0) return 8'd1;
            if (v > MAX_EXTENT_DEF) return 8'(MAX_EXTENT_DEF);
            return v;
        endfunction

        function logic [7:0] sat_origin(logic [7:0] v);
            if (v > MAX_EXTENT_DEF - 1) return 8'(MAX_EXTENT_DEF - 1);
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                REG_BOX_LEFT:   box_left = val;
                REG_BOX_TOP:    box_top = val;
                REG_BOX_WIDTH:  box_width = val;
                REG_BOX_HEIGHT: box_height = val;
                default: ;
            endcase
        endfunction

        function int frame_pixels();
            return int'(sat_extent(box_width)) * int'(sat_extent(box_height));
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void add_byte(logic [7:0] b, logic done);
            out_word_t o;
            o.out_byte   = b;
            o.last       = 1'b0;
            o.frame_done = done;
            burst = {burst, o};
        endfunction

        function void close_run();
            add_byte(run_start, 1'b0);
            add_byte(minor_pos - run_start, 1'b0);
            run_open = 1'b0;
        endfunction

        function void encode_word(in_word_t w);
            logic [7:0] wd, ht, minor_len, major_len;
            wd = sat_extent(box_width);
            ht = sat_extent(box_height);
            burst.delete();
            if (w.command == CMD_BEGIN) begin
                rows_first = (wd >= ht);
                minor_pos  = 8'd0;
                major_pos  = 8'd0;
                run_open   = 1'b0;
                run_start  = 8'd0;
                frame_open = 1'b1;
                add_byte(rows_first ? HDR_ROWS : HDR_COLS, 1'b0);
                add_byte(sat_origin(box_left), 1'b0);
                add_byte(sat_origin(box_top), 1'b0);
                add_byte(wd, 1'b0);
                add_byte(ht, 1'b0);
                n_frames++;
                n_coded++;
            end else if (frame_open) begin
                n_coded++;
                minor_len = rows_first ? wd : ht;
                major_len = rows_first ? ht : wd;
                if (w.inside_req) begin
                    if (!run_open) begin
                        run_open  = 1'b1;
                        run_start = minor_pos;
                    end
                end else if (run_open) begin
                    close_run();
                end
                minor_pos++;
                if (minor_pos >= minor_len) begin
                    if (run_open) close_run();
                    minor_pos  = 8'd0;
                    major_pos++;
                    frame_open = (major_pos < major_len);
                    add_byte(LINE_END, !frame_open);
                end
            end
            if (burst.size() > 0) begin
                burst[burst.size()-1].last = 1'b1;
                expected_bytes = {expected_bytes, burst};
            end
        endfunction

        function void compare_byte(out_word_t got);
            out_word_t want;
            n_checked++;
            if (expected_bytes.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $error("byte %02h arrived with nothing expected", got.out_byte);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            end
            if (got.last !== want.last) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $error("last: expected %0b, got %0b", want.last, got.last);
            end
            if (got.frame_done !== want.frame_done) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = REG_BOX_LEFT;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_word_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_word_t  m_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;

    rle_byte_tracker tracker;

    mask_scanline_run_encoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_mask_scanline_run_encoder NOT OK");
            $finish;
        end
    end

    // Result side: random back-pressure, check every byte taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.compare_byte(m_data);
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input logic cmd, input logic ins);
        in_word_t w;
        w.command    = cmd;
        w.inside_req = ins;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.encode_word(w);
    endtask

    // Hold the input until every owed byte has come out, then let the pipe settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [7:0] left, input logic [7:0] top,
                             input logic [7:0] wd, input logic [7:0] ht);
        logic [1:0] idx [4];
        logic [7:0] val [4];
        idx = '{REG_BOX_LEFT, REG_BOX_TOP, REG_BOX_WIDTH, REG_BOX_HEIGHT};
        val = '{left, top, wd, ht};
        cfg_we <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
            tracker.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        tracker.n_configs++;
    endtask

    function automatic logic [7:0] extreme_extent();
        case ($urandom_range(3))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    task automatic random_config();
        logic [7:0] wd, ht;
        wait_idle();
        if ($urandom_range(9) == 0) begin
            wd = extreme_extent();
            ht = ($urandom_range(1) == 1) ? extreme_extent() : 8'($urandom_range(1, 8));
        end else begin
            wd = 8'($urandom_range(1, 8));
            ht = 8'($urandom_range(1, 8));
        end
        configure(8'($urandom_range(255)), 8'($urandom_range(255)), wd, ht);
    endtask

    // Mostly complete frames; some cut short (next begin drops them), some with stray pixels.
    task automatic random_frame();
        int total, n, lim, density, shape;
        send_word(CMD_BEGIN, 1'($urandom_range(1)));
        total   = tracker.frame_pixels();
        density = $urandom_range(100);
        shape   = $urandom_range(99);
        lim     = (total < 40) ? total : 40;
        if (total > 64 || shape < 10) n = $urandom_range(1, lim);
        else if (shape < 20)          n = total + $urandom_range(1, 3);
        else                          n = total;
        for (int i = 0; i < n; i++)
            send_word(CMD_PIXEL, 1'($urandom_range(99) < density));
    endtask

    task automatic run_phase(input int target);
        int start;
        start = tracker.n_coded;
        while (tracker.n_coded - start < target) begin
            if ($urandom_range(5) == 0)      random_config();
            else if ($urandom_range(9) == 0) wait_idle();
            random_frame();
        end
    endtask

    initial begin
        tracker = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 13;
        recv_idle_pct = 55;
        // Reset box is 1x1; pixels before any begin are dropped.
        send_word(CMD_PIXEL, 1'b1);
        send_word(CMD_PIXEL, 1'b0);
        send_word(CMD_BEGIN, 1'b1);
        send_word(CMD_PIXEL, 1'b1);
        send_word(CMD_PIXEL, 1'b1);
        wait_idle();
        // Out-of-range registers saturate; tall box scans by columns.
        configure(8'd255, 8'd254, 8'd0, 8'd255);
        send_word(CMD_BEGIN, 1'b0);
        send_word(CMD_PIXEL, 1'b1);
        send_word(CMD_PIXEL, 1'b0);
        send_word(CMD_BEGIN, 1'b0);
        wait_idle();
        // Widen the box part way through a frame.
        configure(8'd0, 8'd0, 8'd3, 8'd2);
        send_word(CMD_BEGIN, 1'b0);
        send_word(CMD_PIXEL, 1'b1);
        send_word(CMD_PIXEL, 1'b0);
        send_word(CMD_PIXEL, 1'b1);
        wait_idle();
        configure(8'd253, 8'd253, 8'd4, 8'd2);
        send_word(CMD_PIXEL, 1'b0);
        send_word(CMD_PIXEL, 1'b1);
        send_word(CMD_PIXEL, 1'b1);
        send_word(CMD_PIXEL, 1'b1);
        run_phase(20);

        send_idle_pct = 55;
        recv_idle_pct = 13;
        run_phase(20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(20);

        // Full-width single row, one run spanning the whole line.
        wait_idle();
        configure(8'd7, 8'd9, 8'd254, 8'd1);
        send_word(CMD_BEGIN, 1'b0);
        for (int i = 0; i < 254; i++) send_word(CMD_PIXEL, 1'b1);
        wait_idle();
        configure(8'd253, 8'd0, 8'd1, 8'd255);
        send_word(CMD_BEGIN, 1'b0);
        for (int i = 0; i < 10; i++) send_word(CMD_PIXEL, 1'($urandom_range(1)));
        wait_idle();
        configure(8'd0, 8'd253, 8'd254, 8'd254);
        send_word(CMD_BEGIN, 1'b1);
        for (int i = 0; i < 10; i++) send_word(CMD_PIXEL, 1'($urandom_range(1)));
        send_word(CMD_BEGIN, 1'b0);

        wait_idle();
        if (tracker.pending() != 0) begin
            tracker.n_errors++;
            $error("%0d bytes never arrived", tracker.pending());
        end
        $display("Encoded %0d frames from %0d coded words over %0d box settings,",
                 tracker.n_frames, tracker.n_coded, tracker.n_configs);
        $display("checked %0d output bytes, %0d mismatches.", tracker.n_checked,
                 tracker.n_errors);
        if (tracker.n_errors == 0) begin
            $display("tb_mask_scanline_run_encoder OK");
        end else begin
            $display("tb_mask_scanline_run_encoder NOT OK");
        end
        $finish;
    end

endmodule
